// ----- hdl/ymr_pkg.sv -----
// Package for the YMODEM batch receiver: protocol characters, result kinds,
// phase encoding, result record type and the CRC-16 byte update function.
// No dependencies.
package ymr_pkg;

   localparam int SizeBits = 31;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [2:0] K_TX      = 3'd0;
   localparam logic [2:0] K_NAME    = 3'd1;
   localparam logic [2:0] K_DATA    = 3'd2;
   localparam logic [2:0] K_HDR_OK  = 3'd3;
   localparam logic [2:0] K_PKT_OK  = 3'd4;
   localparam logic [2:0] K_SUCCESS = 3'd5;
   localparam logic [2:0] K_ERROR   = 3'd6;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // header field tracker
   localparam logic [1:0] HF_NAME = 2'd0;
   localparam logic [1:0] HF_SIZE = 2'd1;
   localparam logic [1:0] HF_REST = 2'd2;

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_WAIT_START = 8'b0000_0010,
      PH_HDR        = 8'b0000_0100,
      PH_WAIT_BLOCK = 8'b0000_1000,
      PH_DATA       = 8'b0001_0000,
      PH_WAIT_EOT2  = 8'b0010_0000,
      PH_WAIT_LAST  = 8'b0100_0000,
      PH_LAST       = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [7:0]          value;
      logic [SizeBits-1:0] file_size;
   } result_type;

   // group of up to four results for one transaction
   typedef struct packed {
      logic [2:0]     count;
      result_type [3:0] res;
   } batch_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
   endfunction

endpackage

// ----- hdl/ymr_core.sv -----
// Protocol state and one-pass result generation for the YMODEM receiver.
// Depends on ymr_pkg.
module ymr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [1:0]        opcode,
   input  logic [7:0]        rx_byte,
   input  logic [15:0]       timeout_ticks,
   output ymr_pkg::batch_type batch
);
   import ymr_pkg::*;

   localparam logic [SizeBits-1:0] SizeMax = {SizeBits{1'b1}};

   phase_type           phase_ff, phase_in;
   logic [7:0]          seq_ff, seq_in;
   logic [10:0]         idx_ff, idx_in;
   logic                long_ff, long_in;
   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          crch_ff, crch_in;
   logic [1:0]          hf_ff, hf_in;
   logic [SizeBits-1:0] sacc_ff, sacc_in;
   logic [SizeBits-1:0] rem_ff, rem_in;
   logic                unl_ff, unl_in;
   logic [16:0]         tmr_ff, tmr_in;
   logic                bad_ff, bad_in;

   logic [10:0]         len;
   logic [7:0]          exp_seq;
   logic [SizeBits+3:0] prod;
   logic [16:0]         limit, tmr_inc;
   logic                crc_ok;

   // results: push helper via index
   result_type          res [4];
   logic [2:0]          cnt;

   always_comb begin
      phase_in = phase_ff; seq_in = seq_ff; idx_in = idx_ff; long_in = long_ff;
      crc_in = crc_ff; crch_in = crch_ff; hf_in = hf_ff; sacc_in = sacc_ff;
      rem_in = rem_ff; unl_in = unl_ff; tmr_in = tmr_ff; bad_in = bad_ff;
      for (int i = 0; i < 4; i++) res[i] = '0;
      cnt = 3'd0;
      len = long_ff ? 11'd1024 : 11'd128;
      exp_seq = (phase_ff == PH_LAST) ? 8'd0 : seq_ff;
      prod = {4'd0, sacc_ff} * (SizeBits+4)'(10) + (SizeBits+4)'(rx_byte - 8'h30);
      crc_ok = ({crch_ff, rx_byte} == crc_ff);
      limit = (phase_ff == PH_HDR || phase_ff == PH_DATA || phase_ff == PH_LAST)
              ? {timeout_ticks, 1'b0} : {1'b0, timeout_ticks};
      tmr_inc = tmr_ff + 17'd1;

      if (go) begin
         case (opcode)
            OP_START: begin
               phase_in = PH_WAIT_START; seq_in = '0; idx_in = '0; long_in = 1'b0;
               crc_in = '0; crch_in = '0; hf_in = HF_NAME; sacc_in = '0;
               rem_in = '0; unl_in = 1'b0; tmr_in = '0; bad_in = 1'b0;
               res[0] = '{K_TX, CH_C, '0}; cnt = 3'd1;
            end
            OP_BYTE: begin
               case (phase_ff)
                  PH_WAIT_START, PH_WAIT_BLOCK, PH_WAIT_LAST: begin
                     if ((rx_byte == CH_SOH) ||
                         (rx_byte == CH_STX && phase_ff != PH_WAIT_LAST)) begin
                        phase_in = (phase_ff == PH_WAIT_START) ? PH_HDR :
                                   (phase_ff == PH_WAIT_BLOCK) ? PH_DATA : PH_LAST;
                        long_in = (rx_byte == CH_STX);
                        idx_in = '0; crc_in = '0; bad_in = 1'b0; tmr_in = '0;
                     end else if (rx_byte == CH_EOT && phase_ff == PH_WAIT_BLOCK) begin
                        res[0] = '{K_TX, CH_NAK, '0}; cnt = 3'd1;
                        phase_in = PH_WAIT_EOT2; tmr_in = '0;
                     end else begin
                        cnt = 3'd4;
                     end
                  end
                  PH_WAIT_EOT2: begin
                     if (rx_byte == CH_EOT) begin
                        res[0] = '{K_TX, CH_ACK, '0};
                        res[1] = '{K_TX, CH_C, '0}; cnt = 3'd2;
                        phase_in = PH_WAIT_LAST; tmr_in = '0;
                     end else cnt = 3'd4;
                  end
                  PH_HDR, PH_DATA, PH_LAST: begin
                     tmr_in = '0;
                     if (idx_ff == 11'd0) begin
                        if (rx_byte != exp_seq) bad_in = 1'b1;
                     end else if (idx_ff == 11'd1) begin
                        if (rx_byte != ~exp_seq) bad_in = 1'b1;
                     end else if (idx_ff < len + 11'd2) begin
                        crc_in = crc16_byte(crc_ff, rx_byte);
                        if (phase_ff == PH_HDR) begin
                           if (hf_ff == HF_NAME) begin
                              if (rx_byte == 8'd0) hf_in = HF_SIZE;
                              else if (!bad_ff) begin
                                 res[0] = '{K_NAME, rx_byte, '0}; cnt = 3'd1;
                              end
                           end else if (hf_ff == HF_SIZE) begin
                              if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
                                 sacc_in = (prod > {4'd0, SizeMax}) ? SizeMax
                                           : prod[SizeBits-1:0];
                              else hf_in = HF_REST;
                           end
                        end else if (phase_ff == PH_DATA && !bad_ff) begin
                           if (unl_ff || rem_ff != '0) begin
                              res[0] = '{K_DATA, rx_byte, '0}; cnt = 3'd1;
                           end
                           if (!unl_ff && rem_ff != '0) rem_in = rem_ff - SizeBits'(1);
                        end
                     end else if (idx_ff == len + 11'd2) begin
                        crch_in = rx_byte;
                     end
                     if (idx_ff < len + 11'd3) begin
                        idx_in = idx_ff + 11'd1;
                     end else if (phase_ff == PH_LAST) begin
                        if (bad_ff) cnt = 3'd4;
                        else begin
                           res[0] = '{K_TX, CH_ACK, '0};
                           res[1] = '{K_SUCCESS, 8'd0, '0}; cnt = 3'd2;
                           phase_in = PH_IDLE;
                        end
                     end else if (bad_ff || !crc_ok) begin
                        cnt = 3'd4;
                     end else begin
                        if (phase_ff == PH_HDR) begin
                           unl_in = (sacc_ff == '0);
                           rem_in = sacc_ff;
                           res[0] = '{K_HDR_OK, 8'd0, sacc_ff};
                           res[1] = '{K_TX, CH_ACK, '0};
                           res[2] = '{K_TX, CH_C, '0}; cnt = 3'd3;
                        end else begin
                           res[0] = '{K_PKT_OK, 8'd0, '0};
                           res[1] = '{K_TX, CH_ACK, '0}; cnt = 3'd2;
                        end
                        seq_in = seq_ff + 8'd1;
                        phase_in = PH_WAIT_BLOCK;
                     end
                  end
                  default: ;
               endcase
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  tmr_in = tmr_inc;
                  if (tmr_inc >= limit) begin
                     if (phase_ff == PH_WAIT_START) begin
                        res[0] = '{K_TX, CH_C, '0}; cnt = 3'd1; tmr_in = '0;
                     end else cnt = 3'd4;
                  end
               end
            end
            default: ;
         endcase
         // failure: three CANs then error, back to idle
         if (cnt == 3'd4) begin
            res[0] = '{K_TX, CH_CAN, '0};
            res[1] = '{K_TX, CH_CAN, '0};
            res[2] = '{K_TX, CH_CAN, '0};
            res[3] = '{K_ERROR, 8'd0, '0};
            phase_in = PH_IDLE; tmr_in = '0;
         end
      end
      batch.count = cnt;
      for (int i = 0; i < 4; i++) batch.res[i] = res[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; seq_ff <= '0; idx_ff <= '0; long_ff <= 1'b0;
         crc_ff <= '0; crch_ff <= '0; hf_ff <= HF_NAME; sacc_ff <= '0;
         rem_ff <= '0; unl_ff <= 1'b0; tmr_ff <= '0; bad_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; seq_ff <= seq_in; idx_ff <= idx_in; long_ff <= long_in;
         crc_ff <= crc_in; crch_ff <= crch_in; hf_ff <= hf_in; sacc_ff <= sacc_in;
         rem_ff <= rem_in; unl_ff <= unl_in; tmr_ff <= tmr_in; bad_ff <= bad_in;
      end
   end

   // a failure always drops back to idle
   assert property (@(posedge clock) disable iff (reset)
      go && batch.count == 3'd4 |=> phase_ff == PH_IDLE)
      else $error("failure did not return to idle");
   // byte index never passes the end of a long packet
   assert property (@(posedge clock) disable iff (reset) idx_ff <= 11'd1027)
      else $error("byte index out of range");
   // nothing is produced without a transaction
   assert property (@(posedge clock) disable iff (reset)
      !go |-> batch.count == 3'd0)
      else $error("results without a transaction");
endmodule

// ----- hdl/ymr_out.sv -----
// Result queue: holds the batch of one transaction and hands out its results
// one per transaction on the rsp channel, taking the next batch as the last goes.
// Depends on ymr_pkg.
module ymr_out (
   input  logic                         clock,
   input  logic                         reset,
   input  ymr_pkg::batch_type           batch,
   input  logic                         load,
   output logic                         busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_kind,
   output logic [7:0]                   rsp_value,
   output logic [ymr_pkg::SizeBits-1:0] rsp_file_size,
   output logic                         rsp_last
);
   import ymr_pkg::*;

   batch_type   buf_ff, buf_in;
   logic [2:0]  pos_ff, pos_in;
   logic        take;

   assign busy      = (buf_ff.count != 3'd0) && !(take && rsp_last);
   assign rsp_valid = (buf_ff.count != 3'd0);
   assign rsp_kind      = buf_ff.res[pos_ff[1:0]].kind;
   assign rsp_value     = buf_ff.res[pos_ff[1:0]].value;
   assign rsp_file_size = buf_ff.res[pos_ff[1:0]].file_size;
   assign rsp_last      = (pos_ff + 3'd1 == buf_ff.count);
   assign take = rsp_valid && rsp_ready;

   // advance within the batch, reload on the final result
   always_comb begin
      buf_in = buf_ff;
      pos_in = pos_ff;
      if (take) begin
         pos_in = pos_ff + 3'd1;
         if (rsp_last) begin
            buf_in.count = 3'd0;
            pos_in = '0;
         end
      end
      if (load) begin
         buf_in = batch;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff.count <= '0;
         pos_ff <= '0;
      end else begin
         buf_ff.count <= buf_in.count;
         pos_ff <= pos_in;
      end
      buf_ff.res <= buf_in.res;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pos_ff < buf_ff.count)
      else $error("result position past batch");
   assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid || (take && rsp_last))
      else $error("batch overwritten");
   assert property (@(posedge clock) disable iff (reset)
      load && batch.count != 3'd0 |=> rsp_valid && pos_ff == 3'd0)
      else $error("loaded batch not shown");
endmodule

// ----- hdl/ymodem_batch_receiver.sv -----
// YMODEM (CRC-16) single-file receiver. Each req transaction (start, received
// byte or timer tick) is processed in the cycle it is accepted and yields zero
// to four rsp transactions, the final one flagged by rsp_last. req_ready is
// high whenever the result register is empty or its final result is taken that
// cycle, so with rsp_ready held high an item that yields at most one result is
// taken every cycle; one yielding more holds off the next until its last goes. csr_wr_en
// loads the timeout (reset 100 ticks) and is only to be used while idle.
// Depends on ymr_pkg, ymr_core and ymr_out.
module ymodem_batch_receiver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_kind,
   output logic [7:0]                   rsp_value,
   output logic [ymr_pkg::SizeBits-1:0] rsp_file_size,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [15:0]                  csr_wr_data
);
   import ymr_pkg::*;

   logic [15:0] timeout_ff;
   logic        go, busy;
   batch_type   batch;

   assign req_ready = !busy;
   assign go = req_valid && req_ready;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= TIMEOUT_RESET;
      else if (csr_wr_en) timeout_ff <= csr_wr_data;
   end

   ymr_core u_core (
      .clock, .reset, .go, .opcode(req_opcode), .rx_byte(req_rx_byte),
      .timeout_ticks(timeout_ff), .batch
   );

   ymr_out u_out (
      .clock, .reset, .batch, .load(go), .busy,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_value, .rsp_file_size, .rsp_last
   );
endmodule
